// ----- hdl/sfprc_pkg.sv -----
package sfprc_pkg;

   localparam int unsigned POS_W  = 4;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned VAL_W  = 16;
   localparam int unsigned STAT_W = 2;
   localparam int unsigned IDX_W  = 2;

   localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h40;
   localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h5E;
   localparam logic [BYTE_W-1:0] HDR_THIRD  = 8'h76;

   localparam logic [POS_W-1:0] POS_HDR0   = 4'd0;
   localparam logic [POS_W-1:0] POS_HDR1   = 4'd1;
   localparam logic [POS_W-1:0] POS_HDR2   = 4'd2;
   localparam logic [POS_W-1:0] POS_SKIP0  = 4'd3;
   localparam logic [POS_W-1:0] POS_SKIP1  = 4'd4;
   localparam logic [POS_W-1:0] POS_X_HI   = 4'd5;
   localparam logic [POS_W-1:0] POS_X_LO   = 4'd6;
   localparam logic [POS_W-1:0] POS_D_HI   = 4'd7;
   localparam logic [POS_W-1:0] POS_D_LO   = 4'd8;
   localparam logic [POS_W-1:0] POS_CSUM   = 4'd9;

   localparam logic [STAT_W-1:0] ST_CHECKSUM_ERROR = 2'd0;
   localparam logic [STAT_W-1:0] ST_OUT_OF_RANGE   = 2'd1;
   localparam logic [STAT_W-1:0] ST_ACCEPTED       = 2'd2;

   localparam logic [IDX_W-1:0] REG_X_MIN     = 2'd0;
   localparam logic [IDX_W-1:0] REG_X_MAX     = 2'd1;
   localparam logic [IDX_W-1:0] REG_DEPTH_MIN = 2'd2;

   localparam logic [VAL_W-1:0] X_MIN_RESET     = 16'd10;
   localparam logic [VAL_W-1:0] X_MAX_RESET     = 16'd630;
   localparam logic [VAL_W-1:0] DEPTH_MIN_RESET = 16'd500;

   typedef struct packed {
      logic [VAL_W-1:0] x_minimum;
      logic [VAL_W-1:0] x_maximum;
      logic [VAL_W-1:0] depth_minimum;
   } sfprc_limits_type;

endpackage

// ----- hdl/serial_frame_parser_range_check_top.sv -----
// Serial frame parser. Takes one received byte per transaction on req_ and
// looks for a 10-byte frame: '@' '^' 'v', two ignored bytes, a big-endian
// 16-bit position, a big-endian 16-bit depth and an 8-bit additive checksum
// over bytes 0 to 8. A wrong first byte is skipped; a wrong second or third
// byte restarts the search. The checksum byte yields one rsp_ transaction
// with status (0 checksum error, 1 out of range, 2 accepted), position and
// depth; no other byte yields one. One byte is taken per cycle; the result
// register is the only stage, so req_tready drops only while a result waits
// and rsp_tready is low. Limits must be written on csr_ only while idle, which is
// not enforced; index 0 is x_minimum, 1 x_maximum, 2 depth_minimum, others ignored.
module serial_frame_parser_range_check_top
   import sfprc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] rx_byte
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [31:0]        rsp_tdata,   // [15:0] x_position, [31:16] depth_value
   output logic [1:0]         rsp_tuser,   // [1:0] frame_status
   input  logic               csr_we,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [VAL_W-1:0]   csr_wdata
);

   sfprc_limits_type    limits_ff;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [BYTE_W-1:0]   sum_ff, sum_in;
   logic [VAL_W-1:0]    x_ff, x_in;
   logic [VAL_W-1:0]    depth_ff, depth_in;
   logic                out_valid_ff, out_valid_in;
   logic [STAT_W-1:0]   out_status_ff;
   logic [VAL_W-1:0]    out_x_ff;
   logic [VAL_W-1:0]    out_depth_ff;
   logic [STAT_W-1:0]   status;
   logic [BYTE_W-1:0]   rx_byte;
   logic                accept;
   logic                emit;

   assign rx_byte    = req_tdata;
   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.x_minimum     <= X_MIN_RESET;
         limits_ff.x_maximum     <= X_MAX_RESET;
         limits_ff.depth_minimum <= DEPTH_MIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_X_MIN:     limits_ff.x_minimum     <= csr_wdata;
            REG_X_MAX:     limits_ff.x_maximum     <= csr_wdata;
            REG_DEPTH_MIN: limits_ff.depth_minimum <= csr_wdata;
            default:       ;
         endcase
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      x_in     = x_ff;
      depth_in = depth_ff;
      emit     = 1'b0;
      if (accept) begin
         case (pos_ff)
            POS_HDR0: begin
               if (rx_byte == HDR_FIRST) begin
                  pos_in = pos_ff + 1'b1;
                  sum_in = sum_ff + rx_byte;
               end
            end
            POS_HDR1, POS_HDR2: begin
               if ((pos_ff == POS_HDR1 && rx_byte == HDR_SECOND) ||
                   (pos_ff == POS_HDR2 && rx_byte == HDR_THIRD)) begin
                  pos_in = pos_ff + 1'b1;
                  sum_in = sum_ff + rx_byte;
               end else begin
                  pos_in = POS_HDR0;
                  sum_in = '0;
               end
            end
            POS_SKIP0, POS_SKIP1, POS_X_HI, POS_X_LO, POS_D_HI, POS_D_LO: begin
               pos_in = pos_ff + 1'b1;
               sum_in = sum_ff + rx_byte;
               if (pos_ff == POS_X_HI)  x_in[15:8]     = rx_byte;
               if (pos_ff == POS_X_LO)  x_in[7:0]      = rx_byte;
               if (pos_ff == POS_D_HI)  depth_in[15:8] = rx_byte;
               if (pos_ff == POS_D_LO)  depth_in[7:0]  = rx_byte;
            end
            POS_CSUM: begin
               emit   = 1'b1;
               pos_in = POS_HDR0;
               sum_in = '0;
            end
            default: begin
               pos_in = POS_HDR0;
               sum_in = '0;
            end
         endcase
      end
   end

   sfprc_check u_check (
      .limits       (limits_ff),
      .running_sum  (sum_ff),
      .rx_byte      (rx_byte),
      .x_position   (x_ff),
      .depth_value  (depth_ff),
      .frame_status (status)
   );

   assign out_valid_in = emit || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_HDR0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      depth_ff <= depth_in;
      if (emit) begin
         out_status_ff <= status;
         out_x_ff      <= x_ff;
         out_depth_ff  <= depth_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_depth_ff, out_x_ff};
   assign rsp_tuser  = out_status_ff;

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_CSUM)
      else $error("byte position beyond checksum byte");

   a_idle_sum: assert property (@(posedge clock) disable iff (reset)
      pos_ff == POS_HDR0 |-> sum_ff == '0)
      else $error("running sum not cleared at frame start");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      accept && pos_ff == POS_CSUM |=> pos_ff == POS_HDR0 && rsp_tvalid)
      else $error("no result or restart after checksum byte");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(accept && pos_ff == POS_CSUM))
      else $error("result without checksum byte");

   a_rsp_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == ST_CHECKSUM_ERROR || rsp_tuser == ST_OUT_OF_RANGE ||
                     rsp_tuser == ST_ACCEPTED)
      else $error("invalid frame status");

endmodule

// ----- hdl/sfprc_check.sv -----
module sfprc_check
   import sfprc_pkg::*;
(
   input  sfprc_limits_type    limits,
   input  logic [BYTE_W-1:0]   running_sum,
   input  logic [BYTE_W-1:0]   rx_byte,
   input  logic [VAL_W-1:0]    x_position,
   input  logic [VAL_W-1:0]    depth_value,
   output logic [STAT_W-1:0]   frame_status
);

   logic out_of_range;

   assign out_of_range = (x_position < limits.x_minimum) ||
                         (x_position > limits.x_maximum) ||
                         (depth_value < limits.depth_minimum);

   always_comb begin
      if (running_sum != rx_byte) begin
         frame_status = ST_CHECKSUM_ERROR;
      end else if (out_of_range) begin
         frame_status = ST_OUT_OF_RANGE;
      end else begin
         frame_status = ST_ACCEPTED;
      end
   end

endmodule

// ----- tb/sv/serial_frame_parser_range_check_top_tb.sv -----
module serial_frame_parser_range_check_top_tb
   import sfprc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned QUIET_LIMIT   = 5000;
   localparam int unsigned PHASES        = 8;
   localparam int unsigned PHASE_BYTES   = 232;

   // index with no register behind it; writes to it must be ignored
   localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [VAL_W-1:0]  x_position;
      logic [VAL_W-1:0]  depth_value;
   } frame_report_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              pinned;
      frame_report_type  report;
   } stimulus_row_type;

   localparam logic [STAT_W+2*VAL_W:0] FREE = '0;

   // good frame at the limits, header breaks, then a frame with a bad checksum
   localparam stimulus_row_type DIRECTED_ROWS [26] = '{
      {HDR_FIRST, FREE}, {HDR_SECOND, FREE}, {HDR_THIRD, FREE},
      {8'h00, FREE}, {8'hFF, FREE},
      {8'h02, FREE}, {8'h76, FREE}, {8'h01, FREE}, {8'hF4, FREE},
      {8'h80, 1'b1, ST_ACCEPTED, 16'h0276, 16'h01F4},
      {8'hFF, FREE},
      {HDR_FIRST, FREE}, {8'h00, FREE},
      {HDR_FIRST, FREE}, {HDR_SECOND, FREE}, {HDR_FIRST, FREE},
      {HDR_FIRST, FREE}, {HDR_SECOND, FREE}, {HDR_THIRD, FREE},
      {8'h00, FREE}, {8'h00, FREE},
      {8'hFF, FREE}, {8'hFF, FREE}, {8'hFF, FREE}, {8'hFF, FREE},
      {8'h00, 1'b1, ST_CHECKSUM_ERROR, 16'hFFFF, 16'hFFFF}
   };

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [7:0]         req_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [31:0]        rsp_tdata;
   logic [1:0]         rsp_tuser;
   logic               csr_we;
   logic [IDX_W-1:0]   csr_index;
   logic [VAL_W-1:0]   csr_wdata;

   // predictor state
   logic [POS_W-1:0]  frame_pos     = POS_HDR0;
   logic [BYTE_W-1:0] frame_sum     = '0;
   logic [VAL_W-1:0]  x_acc         = '0;
   logic [VAL_W-1:0]  depth_acc     = '0;
   logic [VAL_W-1:0]  lim_x_min     = X_MIN_RESET;
   logic [VAL_W-1:0]  lim_x_max     = X_MAX_RESET;
   logic [VAL_W-1:0]  lim_depth_min = DEPTH_MIN_RESET;

   frame_report_type reports_due [$];
   frame_report_type oldest_report;

   bit          steady = 1'b0;
   int unsigned rsp_stall = 0;
   int unsigned quiet_cycles = 0;
   int unsigned failures = 0;
   int unsigned bytes_sent = 0;
   int unsigned reports_checked = 0;
   int unsigned drains = 0;
   int unsigned settings_used = 1;
   int unsigned status_seen [3] = '{0, 0, 0};

   serial_frame_parser_range_check_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void restart_search();
      frame_pos = POS_HDR0;
      frame_sum = '0;
   endfunction

   function automatic void take_byte(input logic [BYTE_W-1:0] b);
      frame_sum = frame_sum + b;
      frame_pos = frame_pos + 1'b1;
   endfunction

   function automatic void track_byte(input logic [BYTE_W-1:0] b, output bit produced,
                                      output frame_report_type report);
      produced = 1'b0;
      report   = '0;
      case (frame_pos)
         POS_HDR0: begin
            if (b == HDR_FIRST) take_byte(b);
         end
         POS_HDR1: begin
            if (b == HDR_SECOND) take_byte(b);
            else restart_search();
         end
         POS_HDR2: begin
            if (b == HDR_THIRD) take_byte(b);
            else restart_search();
         end
         POS_SKIP0, POS_SKIP1: take_byte(b);
         POS_X_HI: begin
            x_acc[15:8] = b;
            take_byte(b);
         end
         POS_X_LO: begin
            x_acc[7:0] = b;
            take_byte(b);
         end
         POS_D_HI: begin
            depth_acc[15:8] = b;
            take_byte(b);
         end
         POS_D_LO: begin
            depth_acc[7:0] = b;
            take_byte(b);
         end
         POS_CSUM: begin
            produced           = 1'b1;
            report.x_position  = x_acc;
            report.depth_value = depth_acc;
            if (frame_sum != b)
               report.status = ST_CHECKSUM_ERROR;
            else if (x_acc < lim_x_min || x_acc > lim_x_max || depth_acc < lim_depth_min)
               report.status = ST_OUT_OF_RANGE;
            else
               report.status = ST_ACCEPTED;
            restart_search();
         end
         default: restart_search();
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] near_limit(input logic [VAL_W-1:0] lo,
                                                   input logic [VAL_W-1:0] hi);
      case ($urandom_range(0, 8))
         0: return lo - 16'd1;
         1: return lo;
         2: return lo + 16'd1;
         3: return hi - 16'd1;
         4: return hi;
         5: return hi + 16'd1;
         6: return (lo <= hi) ? lo + 16'($urandom_range(0, hi - lo)) : lo;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit pinned = 1'b0,
                            input frame_report_type pin = '0);
      int unsigned gap;
      bit produced;
      frame_report_type predicted;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      track_byte(b, produced, predicted);
      bytes_sent++;
      if (produced) reports_due.push_back(pinned ? pin : predicted);
      else if (pinned) begin
         $error("directed byte %0h produced no frame report", b);
         failures++;
      end
   endtask

   task automatic send_frame();
      logic [BYTE_W-1:0] frame [10];
      logic [VAL_W-1:0]  x_value;
      logic [VAL_W-1:0]  d_value;
      logic [BYTE_W-1:0] sum;
      x_value  = near_limit(lim_x_min, lim_x_max);
      d_value  = near_limit(lim_depth_min, 16'hFFFF);
      frame[0] = HDR_FIRST;
      frame[1] = HDR_SECOND;
      frame[2] = HDR_THIRD;
      frame[3] = 8'($urandom);
      frame[4] = 8'($urandom);
      frame[5] = x_value[15:8];
      frame[6] = x_value[7:0];
      frame[7] = d_value[15:8];
      frame[8] = d_value[7:0];
      sum = '0;
      for (int i = 0; i < 9; i++) sum = sum + frame[i];
      frame[9] = ($urandom_range(0, 99) < 15) ? sum ^ 8'($urandom_range(1, 255)) : sum;
      for (int i = 0; i < 10; i++) send_byte(frame[i]);
   endtask

   task automatic wait_for_reports();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (reports_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_limits(input logic [VAL_W-1:0] x_min, input logic [VAL_W-1:0] x_max,
                                 input logic [VAL_W-1:0] d_min);
      csr_we    <= 1'b1;
      csr_index <= REG_X_MIN;
      csr_wdata <= x_min;
      @(posedge clock);
      csr_index <= REG_X_MAX;
      csr_wdata <= x_max;
      @(posedge clock);
      csr_index <= REG_DEPTH_MIN;
      csr_wdata <= d_min;
      @(posedge clock);
      csr_index <= REG_UNUSED;
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_we        <= 1'b0;
      lim_x_min     = x_min;
      lim_x_max     = x_max;
      lim_depth_min = d_min;
      settings_used++;
   endtask

   always @(posedge clock) begin
      if (rsp_stall != 0) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= rsp_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall  <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (reports_due.size() == 0) begin
            $error("unexpected frame report: status %0d x_position %0d depth_value %0d",
                   rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16]);
            failures++;
         end else begin
            oldest_report = reports_due.pop_front();
            reports_checked++;
            if (oldest_report.status <= ST_ACCEPTED) status_seen[oldest_report.status]++;
            if (rsp_tuser !== oldest_report.status) begin
               $error("frame_status expected %0d actual %0d", oldest_report.status, rsp_tuser);
               failures++;
            end
            if (rsp_tdata[15:0] !== oldest_report.x_position) begin
               $error("x_position expected %0d actual %0d",
                      oldest_report.x_position, rsp_tdata[15:0]);
               failures++;
            end
            if (rsp_tdata[31:16] !== oldest_report.depth_value) begin
               $error("depth_value expected %0d actual %0d",
                      oldest_report.depth_value, rsp_tdata[31:16]);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("serial_frame_parser_range_check_top test failed");
            $finish;
         end
      end
   end

   initial begin
      int unsigned target;
      int unsigned roll;
      logic [VAL_W-1:0] a;
      logic [VAL_W-1:0] b;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = REG_X_MIN;
      csr_wdata  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         send_byte(DIRECTED_ROWS[i].rx_byte, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].report);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase != 0) begin
            wait_for_reports();
            case (phase)
               1: program_limits(16'h0000, 16'hFFFF, 16'h0000);
               2: program_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
               3: program_limits(16'd1000, 16'd10, 16'h0000);   // inverted x window
               4: program_limits(16'h0000, 16'h0000, 16'h0000);
               default: begin
                  a = 16'($urandom);
                  b = 16'($urandom);
                  program_limits(a < b ? a : b, a < b ? b : a, 16'($urandom_range(0, 40000)));
               end
            endcase
         end
         steady = (phase == 2);
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
               send_frame();
            end else if (roll < 86) begin
               send_byte(HDR_FIRST);
               if ($urandom_range(0, 1)) send_byte(HDR_SECOND);
               send_byte(8'($urandom));
            end else if (roll < 98) begin
               repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end else begin
               wait_for_reports();
               drains++;
            end
         end
      end

      wait_for_reports();
      $display("%0d bytes over %0d limit settings, %0d mid-run drains, %0d frame reports checked",
               bytes_sent, settings_used, drains, reports_checked);
      $display("reports by status: accepted %0d, out of range %0d, checksum error %0d",
               status_seen[ST_ACCEPTED], status_seen[ST_OUT_OF_RANGE],
               status_seen[ST_CHECKSUM_ERROR]);
      if (failures == 0)
         $display("serial_frame_parser_range_check_top test passed");
      else
         $display("serial_frame_parser_range_check_top test failed");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/sfprc_pkg.sv
hdl/sfprc_check.sv
hdl/serial_frame_parser_range_check_top.sv
tb/sv/serial_frame_parser_range_check_top_tb.sv
